// ----- design/fbfl_pkg.sv -----
package fbfl_pkg;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 8;
   localparam int CNT_W   = 9;
   localparam int GRANT_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_NULL_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic       init_start;
      logic       init_step;
      logic       pop_read;
      logic       pop_done;
      logic       push;
      logic       res_pop;
      status_type status;
      logic       load_rsp;
      logic       load_pend;
      logic       pend_to_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic head_none;
      logic idx_bad;
      logic init_last;
      logic slot_free;
   } dp_sts_type;

endpackage

// ----- design/fbfl_ctrl.sv -----
module fbfl_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [fbfl_pkg::OP_W-1:0]    req_operation,
   input  logic                         req_has_block,
   input  fbfl_pkg::dp_sts_type         sts,
   output fbfl_pkg::dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WAIT = 4'b0010,
      S_INIT = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      deliver;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      cmd.status = fbfl_pkg::ST_OK;
      state_in = state_ff;
      deliver  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  fbfl_pkg::OP_INIT: begin
                     cmd.init_start = 1'b1;
                     state_in       = S_INIT;
                  end
                  fbfl_pkg::OP_ALLOC: begin
                     if (sts.head_none) begin
                        cmd.status = fbfl_pkg::ST_EMPTY;
                        deliver    = 1'b1;
                     end else begin
                        cmd.pop_read = 1'b1;
                        state_in     = S_WAIT;
                     end
                  end
                  fbfl_pkg::OP_FREE: begin
                     deliver = 1'b1;
                     if (!req_has_block) begin
                        cmd.status = fbfl_pkg::ST_NULL_FREE;
                     end else if (sts.idx_bad) begin
                        cmd.status = fbfl_pkg::ST_BAD_INDEX;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  default: begin
                     deliver = 1'b1;
                  end
               endcase
            end
         end
         S_WAIT: begin
            cmd.pop_done = 1'b1;
            cmd.res_pop  = 1'b1;
            deliver      = 1'b1;
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               deliver = 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.slot_free) begin
               cmd.pend_to_rsp = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (deliver) begin
         if (sts.slot_free) begin
            cmd.load_rsp = 1'b1;
            state_in     = S_IDLE;
         end else begin
            cmd.load_pend = 1'b1;
            state_in      = S_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_pop_then_wait: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.pop_read) |=> (state_ff == S_WAIT))
      else $error("alloc read not followed by wait");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !sts.slot_free) |=> (state_ff == S_EMIT))
      else $error("pending item dropped while output busy");

   a_wait_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (cmd.load_rsp || cmd.load_pend))
      else $error("alloc result not delivered");

endmodule

// ----- design/fbfl_datapath.sv -----
module fbfl_datapath #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fbfl_pkg::CNT_W-1:0]      csr_data,
   input  logic [fbfl_pkg::IDX_W-1:0]      req_block_index,
   input  fbfl_pkg::dp_cmd_type            cmd,
   output fbfl_pkg::dp_sts_type            sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fbfl_pkg::GRANT_W-1:0]    rsp_granted_index,
   output fbfl_pkg::status_type            rsp_status,
   output logic [fbfl_pkg::CNT_W-1:0]      rsp_free_count
);

   localparam int NW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = $clog2(MAX_BLOCKS);
   localparam logic [NW-1:0] LINK_NONE = NW'(MAX_BLOCKS);

   logic [NW-1:0] link_mem [MAX_BLOCKS];
   logic [NW-1:0] rd_ff;

   logic [fbfl_pkg::CNT_W-1:0] bc_ff;
   logic [NW-1:0] head_ff, head_in;
   logic [NW-1:0] free_ff, free_in;
   logic [NW-1:0] limit_ff, limit_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] last_ff, last_in;
   logic [NW-1:0] eff_n;
   logic [31:0]   bc_wide;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [NW-1:0] mem_wd;

   logic [fbfl_pkg::GRANT_W-1:0] res_granted;
   logic [fbfl_pkg::CNT_W-1:0]   res_count;

   logic [fbfl_pkg::GRANT_W-1:0] pend_granted_ff;
   fbfl_pkg::status_type         pend_status_ff;
   logic [fbfl_pkg::CNT_W-1:0]   pend_count_ff;

   logic [fbfl_pkg::GRANT_W-1:0] rsp_granted_ff;
   fbfl_pkg::status_type         rsp_status_ff;
   logic [fbfl_pkg::CNT_W-1:0]   rsp_count_ff;
   logic                         rsp_valid_ff;

   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         bc_ff <= csr_data;
      end
   end

   // block count clamped to 1 .. MAX_BLOCKS
   assign bc_wide = 32'(bc_ff);
   always_comb begin
      if (bc_wide == 32'd0) begin
         eff_n = NW'(1);
      end else if (bc_wide > 32'(MAX_BLOCKS)) begin
         eff_n = LINK_NONE;
      end else begin
         eff_n = NW'(bc_wide);
      end
   end

   assign sts.head_none = head_ff >= LINK_NONE;
   assign sts.idx_bad   = 32'(req_block_index) >= 32'(limit_ff);
   assign sts.init_last = cur_ff == last_ff;
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      head_in  = head_ff;
      free_in  = free_ff;
      limit_in = limit_ff;
      cur_in   = cur_ff;
      last_in  = last_ff;
      if (cmd.init_start) begin
         cur_in  = '0;
         last_in = eff_n - NW'(1);
      end
      if (cmd.init_step) begin
         cur_in = cur_ff + NW'(1);
         if (sts.init_last) begin
            head_in  = '0;
            free_in  = last_ff + NW'(1);
            limit_in = last_ff + NW'(1);
         end
      end
      if (cmd.push) begin
         head_in = NW'(req_block_index);
         if (free_ff < LINK_NONE) begin
            free_in = free_ff + NW'(1);
         end
      end
      if (cmd.pop_done) begin
         head_in = (rd_ff > LINK_NONE) ? LINK_NONE : rd_ff;
         if (free_ff != '0) begin
            free_in = free_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= LINK_NONE;
         free_ff  <= '0;
         limit_ff <= '0;
         cur_ff   <= '0;
         last_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         free_ff  <= free_in;
         limit_ff <= limit_in;
         cur_ff   <= cur_in;
         last_ff  <= last_in;
      end
   end

   // link memory, one write and one registered read
   assign mem_we = cmd.push || cmd.init_step;
   assign mem_wa = cmd.init_step ? cur_ff[AW-1:0] : AW'(req_block_index);
   assign mem_wd = cmd.init_step ? (sts.init_last ? LINK_NONE : cur_ff + NW'(1)) : head_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      if (cmd.pop_read) begin
         rd_ff <= link_mem[head_ff[AW-1:0]];
      end
   end

   assign res_granted = cmd.res_pop ? fbfl_pkg::GRANT_W'(head_ff) : '0;
   assign res_count   = fbfl_pkg::CNT_W'(free_in);

   always_ff @(posedge clock) begin
      if (cmd.load_pend) begin
         pend_granted_ff <= res_granted;
         pend_status_ff  <= cmd.status;
         pend_count_ff   <= res_count;
      end
      if (cmd.load_rsp) begin
         rsp_granted_ff <= res_granted;
         rsp_status_ff  <= cmd.status;
         rsp_count_ff   <= res_count;
      end else if (cmd.pend_to_rsp) begin
         rsp_granted_ff <= pend_granted_ff;
         rsp_status_ff  <= pend_status_ff;
         rsp_count_ff   <= pend_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp || cmd.pend_to_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_count    = rsp_count_ff;

   a_push_sets_head: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.push) |=> (head_ff == $past(NW'(req_block_index))))
      else $error("freed block not at head");

   a_init_done: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.init_step && sts.init_last)
         |=> (head_ff == '0 && free_ff == limit_ff))
      else $error("init finished with inconsistent head or count");

   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("output item lost under stall");

endmodule

// ----- design/fixed_block_free_list_core.sv -----
// free-list manager for a pool of equal-sized blocks, addressed by index
// req channel: one item per operation (init, allocate, free); csr channel
// writes the block count, which is used from the next init and is to be
// written only while no item is in flight
// rsp channel: exactly one item per request, with granted index, status
// and the free count after the operation
// free, ignored operations and allocate from an empty list: 1 cycle per item
// allocate: 2 cycles per item, set by the registered read of the link
// memory for the next head
// init: clamped block count + 1 cycles, one link memory write per block
// the result is valid in the output register the cycle after the last
// cycle of its operation
// a result is held in the output register; if that is still full the
// item waits in a pending register and the next request is held off
// until the output drains, so a stalled receiver stops the block with
// nothing lost
// after reset the list is empty (allocate reports empty), the free count
// is zero and the block count is 256; link entries are undefined until
// an init writes them
module fixed_block_free_list_core #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data,     // block_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // operation[1:0], block_index[9:2], zero pad
   input  logic        req_tuser,    // has_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // granted_index[7:0], free_count[16:8], zero pad
   output logic [1:0]  rsp_tuser     // status
);

   fbfl_pkg::dp_cmd_type          cmd;
   fbfl_pkg::dp_sts_type          sts;
   logic [fbfl_pkg::GRANT_W-1:0]  granted;
   fbfl_pkg::status_type          status;
   logic [fbfl_pkg::CNT_W-1:0]    free_count;

   fbfl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_operation (req_tdata[1:0]),
      .req_has_block (req_tuser),
      .sts           (sts),
      .cmd           (cmd)
   );

   fbfl_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_block_index   (req_tdata[9:2]),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_granted_index (granted),
      .rsp_status        (status),
      .rsp_free_count    (free_count)
   );

   assign rsp_tdata = {7'd0, free_count, granted};
   assign rsp_tuser = status;

endmodule
